// ===== src/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Register indexes and fixed constants of the barometric compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_AC1_AC2   = 3'd0;
	localparam logic [2:0] REG_AC3_AC4   = 3'd1;
	localparam logic [2:0] REG_AC5_AC6   = 3'd2;
	localparam logic [2:0] REG_B1_B2     = 3'd3;
	localparam logic [2:0] REG_MC_MD     = 3'd4;
	localparam logic [2:0] REG_OVERSAMP  = 3'd5;

	// compensation constants
	localparam logic [31:0] B6_OFFSET  = 32'd4000;
	localparam logic [31:0] B4_BIAS    = 32'd32768;
	localparam logic [31:0] OSS_SCALE  = 32'd50000;
	localparam logic [31:0] P_COEF1    = 32'd3038;
	localparam logic [31:0] P_COEF2    = 32'hFFFF_E343; // -7357
	localparam logic [31:0] P_COEF3    = 32'd3791;

	localparam logic signed [31:0] TEMP_MAX  = 32'sd32767;
	localparam logic signed [31:0] TEMP_MIN  = -32'sd32768;
	localparam logic signed [31:0] PRES_MAX  = 32'sd262143;

	// divider sizes: first numerator magnitude of MC * 2048
	localparam int DIV1_NW = 27;
	localparam int DIV1_SW = 58;
	localparam int DIV2_SW = 18;

endpackage

// ===== src/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div #(
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic [DW-1:0] rem_s  [NW];
	logic [NW-1:0] num_s  [NW];
	logic [NW-1:0] quo_s  [NW];
	logic [DW-1:0] den_s  [NW];
	logic [SW-1:0] side_s [NW];
	logic          v_s    [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [NW-1:0] num_in;
		logic [NW-1:0] quo_in;
		logic [DW-1:0] den_in;
		logic [SW-1:0] side_in_i;
		logic          v_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;
		logic [NW-1:0] quo_nx;

		if (i == 0) begin : g_first
			assign rem_in    = '0;
			assign num_in    = num;
			assign quo_in    = '0;
			assign den_in    = den;
			assign side_in_i = side_in;
			assign v_in      = in_valid;
		end else begin : g_next
			assign rem_in    = rem_s[i-1];
			assign num_in    = num_s[i-1];
			assign quo_in    = quo_s[i-1];
			assign den_in    = den_s[i-1];
			assign side_in_i = side_s[i-1];
			assign v_in      = v_s[i-1];
		end

		// trial subtract of the divisor from the shifted remainder
		assign trial = {rem_in, num_in[NW-1-i]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = (trial >= {1'b0, den_in});

		always_comb begin
			quo_nx = quo_in;
			quo_nx[NW-1-i] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				num_s[i]  <= num_in;
				quo_s[i]  <= quo_nx;
				den_s[i]  <= den_in;
				side_s[i] <= side_in_i;
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign quo       = quo_s[NW-1];
	assign side_out  = side_s[NW-1];

endmodule

// ===== src/barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Load the calibration words and the oversampling setting through the
//   write port (cfg_we, cfg_index, cfg_data) while no transaction is in
//   flight. Each input transaction carries one raw temperature word and one
//   raw 24-bit pressure reading; each yields one output transaction with
//   temperature in 0.1 degC, pressure in Pa and a divide fault flag.
//   The path has one front stage, a 27-stage divider for the
//   temperature term, six multiply stages, a 32-stage divider for pressure
//   and three final stages. One transaction enters per cycle unless stalled.
//   Reset clears all calibration registers and every stage valid bit.
//   When the receiver stalls, the whole pipeline holds in place; in_ready
//   drops only while a finished result waits at the output.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation
	import bpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        raw_temperature,
	input  logic [23:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] temperature_decidegrees,
	output logic [17:0]        pressure_pascal,
	output logic               divide_fault
);

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;

	// latch configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC1_AC2:  ac12_q <= cfg_data;
				REG_AC3_AC4:  ac34_q <= cfg_data;
				REG_AC5_AC6:  ac56_q <= cfg_data;
				REG_B1_B2:    b12_q  <= cfg_data;
				REG_MC_MD:    mcmd_q <= cfg_data;
				REG_OVERSAMP: oss_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// coefficients widened to 32 bits
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = {{16{ac12_q[31]}}, ac12_q[31:16]};
	assign ac2 = {{16{ac12_q[15]}}, ac12_q[15:0]};
	assign ac3 = {{16{ac34_q[31]}}, ac34_q[31:16]};
	assign ac4 = {16'b0, ac34_q[15:0]};
	assign ac5 = {16'b0, ac56_q[31:16]};
	assign ac6 = {16'b0, ac56_q[15:0]};
	assign b1  = {{16{b12_q[31]}}, b12_q[31:16]};
	assign b2  = {{16{b12_q[15]}}, b12_q[15:0]};
	assign mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
	assign md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: temperature product and pressure alignment
	logic [31:0] t_prod;
	logic [3:0]  up_sh;
	logic [31:0] x1_s1;
	logic [23:0] up_s1;
	logic        v_s1;

	assign t_prod = ({16'b0, raw_temperature} - ac6) * ac5;
	assign up_sh  = 4'd8 - {2'b0, oss_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= $signed(t_prod) >>> 15;
			up_s1 <= raw_pressure >> up_sh;
		end
	end

	// signed division MC * 2048 / (X1 + MD) through magnitudes
	logic [31:0]         den1, num1, den1_mag, num1_neg;
	logic [DIV1_NW-1:0]  num1_mag;
	logic                den1_zero, q1_neg;
	logic [DIV1_SW-1:0]  side1_in, side1_out;
	logic [DIV1_NW-1:0]  q1;
	logic                d1_valid;

	assign den1      = x1_s1 + md;
	assign num1      = mc << 11;
	assign num1_neg  = 32'd0 - num1;
	assign den1_zero = (den1 == 32'd0);
	assign q1_neg    = num1[31] ^ den1[31];
	assign num1_mag  = num1[31] ? num1_neg[DIV1_NW-1:0] : num1[DIV1_NW-1:0];
	assign den1_mag  = den1[31] ? (32'd0 - den1) : den1;
	assign side1_in  = {q1_neg, den1_zero, up_s1, x1_s1};

	bpc_div #(.NW(DIV1_NW), .DW(32), .SW(DIV1_SW)) u_div_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.num      (num1_mag),
		.den      (den1_mag),
		.side_in  (side1_in),
		.out_valid(d1_valid),
		.quo      (q1),
		.side_out (side1_out)
	);

	// stage 2: B5, temperature and B6
	logic        d1_neg, d1_fault;
	logic [23:0] d1_up;
	logic [31:0] d1_x1, q1_ext, x2_t, b5;
	logic signed [31:0] t_raw;
	logic [15:0] t_sat;

	assign {d1_neg, d1_fault, d1_up, d1_x1} = side1_out;
	assign q1_ext = {{(32-DIV1_NW){1'b0}}, q1};
	assign x2_t   = d1_neg ? (32'd0 - q1_ext) : q1_ext;
	assign b5     = d1_x1 + x2_t;
	assign t_raw  = $signed(b5 + 32'd8) >>> 4;

	always_comb begin
		if (t_raw > TEMP_MAX) begin
			t_sat = TEMP_MAX[15:0];
		end else if (t_raw < TEMP_MIN) begin
			t_sat = TEMP_MIN[15:0];
		end else begin
			t_sat = t_raw[15:0];
		end
	end

	logic [31:0] b6_s2;
	logic [15:0] temp_s2;
	logic        fault_s2, v_s2;
	logic [23:0] up_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b6_s2    <= b5 - B6_OFFSET;
			temp_s2  <= d1_fault ? 16'd0 : t_sat;
			fault_s2 <= d1_fault;
			up_s2    <= d1_up;
		end
	end

	// stage 3: products of B6
	logic [31:0] b6sq_p, ac2b6_p, ac3b6_p;
	logic [31:0] b6sq_s3, ac2b6_s3, ac3b6_s3;
	logic [15:0] temp_s3;
	logic        fault_s3, v_s3;
	logic [23:0] up_s3;

	assign b6sq_p  = b6_s2 * b6_s2;
	assign ac2b6_p = ac2 * b6_s2;
	assign ac3b6_p = ac3 * b6_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b6sq_s3  <= $signed(b6sq_p) >>> 12;
			ac2b6_s3 <= $signed(ac2b6_p) >>> 11;
			ac3b6_s3 <= $signed(ac3b6_p) >>> 13;
			temp_s3  <= temp_s2;
			fault_s3 <= fault_s2;
			up_s3    <= up_s2;
		end
	end

	// stage 4: B2 and B1 terms
	logic [31:0] b2p, b1p;
	logic [31:0] p1_s4, p2_s4, ac2b6_s4, ac3b6_s4;
	logic [15:0] temp_s4;
	logic        fault_s4, v_s4;
	logic [23:0] up_s4;

	assign b2p = b2 * b6sq_s3;
	assign b1p = b1 * b6sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s4    <= $signed(b2p) >>> 11;
			p2_s4    <= $signed(b1p) >>> 16;
			ac2b6_s4 <= ac2b6_s3;
			ac3b6_s4 <= ac3b6_s3;
			temp_s4  <= temp_s3;
			fault_s4 <= fault_s3;
			up_s4    <= up_s3;
		end
	end

	// stage 5: B3 and the B4 multiplicand
	logic [31:0] x3a, b3_pre, x3b;
	logic [31:0] b3_s5, m_s5;
	logic [15:0] temp_s5;
	logic        fault_s5, v_s5;
	logic [23:0] up_s5;

	assign x3a    = p1_s4 + ac2b6_s4;
	assign b3_pre = (((ac1 << 2) + x3a) << oss_q) + 32'd2;
	assign x3b    = $signed(ac3b6_s4 + p2_s4 + 32'd2) >>> 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b3_s5    <= $signed(b3_pre) >>> 2;
			m_s5     <= x3b + B4_BIAS;
			temp_s5  <= temp_s4;
			fault_s5 <= fault_s4;
			up_s5    <= up_s4;
		end
	end

	// stage 6: B4 and UP - B3
	logic [31:0] b4_p;
	logic [31:0] b4_s6, diff_s6;
	logic [15:0] temp_s6;
	logic        fault_s6, v_s6;

	assign b4_p = ac4 * m_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b4_s6    <= b4_p >> 15;
			diff_s6  <= {8'b0, up_s5} - b3_s5;
			temp_s6  <= temp_s5;
			fault_s6 <= fault_s5;
		end
	end

	// stage 7: B7
	logic [31:0] b7_s7, b4_s7;
	logic [15:0] temp_s7;
	logic        fault_s7, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b7_s7    <= diff_s6 * (OSS_SCALE >> oss_q);
			b4_s7    <= b4_s6;
			temp_s7  <= temp_s6;
			fault_s7 <= fault_s6;
		end
	end

	// unsigned pressure division, operand form chosen by the top bit of B7
	logic [31:0]        num2, q2;
	logic [DIV2_SW-1:0] side2_in, side2_out;
	logic               d2_valid;

	assign num2     = b7_s7[31] ? b7_s7 : (b7_s7 << 1);
	assign side2_in = {b7_s7[31], fault_s7 || (b4_s7 == 32'd0), temp_s7};

	bpc_div #(.NW(32), .DW(32), .SW(DIV2_SW)) u_div_pres (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s7),
		.num      (num2),
		.den      (b4_s7),
		.side_in  (side2_in),
		.out_valid(d2_valid),
		.quo      (q2),
		.side_out (side2_out)
	);

	// stage 8: pressure estimate and its square term
	logic        d2_hi, d2_fault;
	logic [15:0] d2_temp;
	logic [31:0] p_est, p_asr;
	logic [31:0] p_s8, sq_s8;
	logic [15:0] temp_s8;
	logic        fault_s8, v_s8;

	assign {d2_hi, d2_fault, d2_temp} = side2_out;
	assign p_est = d2_hi ? (q2 << 1) : q2;
	assign p_asr = $signed(p_est) >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s8     <= p_est;
			sq_s8    <= p_asr * p_asr;
			temp_s8  <= d2_temp;
			fault_s8 <= d2_fault;
		end
	end

	// stage 9: correction products
	logic [31:0] c1_p, c2_p;
	logic [31:0] p_s9, c1_s9, c2_s9;
	logic [15:0] temp_s9;
	logic        fault_s9, v_s9;

	assign c1_p = sq_s8 * P_COEF1;
	assign c2_p = P_COEF2 * p_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s9     <= p_s8;
			c1_s9    <= $signed(c1_p) >>> 16;
			c2_s9    <= $signed(c2_p) >>> 16;
			temp_s9  <= temp_s8;
			fault_s9 <= fault_s8;
		end
	end

	// stage 10: final pressure, saturate and hold for the receiver
	logic [31:0]        p_corr;
	logic signed [31:0] p_fin;
	logic [17:0]        p_sat;

	// keep the correction shift arithmetic on its own
	assign p_corr = $signed(c1_s9 + c2_s9 + P_COEF3) >>> 4;
	assign p_fin  = p_s9 + p_corr;

	always_comb begin
		if (p_fin < 32'sd0) begin
			p_sat = 18'd0;
		end else if (p_fin > PRES_MAX) begin
			p_sat = PRES_MAX[17:0];
		end else begin
			p_sat = p_fin[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temperature_decidegrees <= temp_s9;
			pressure_pascal         <= fault_s9 ? 18'd0 : p_sat;
			divide_fault            <= fault_s9;
		end
	end

	// a fault always clears the pressure result
	a_fault_zero_pres: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault |-> pressure_pascal == 18'd0)
		else $error("pressure not cleared on divide fault");

	// a zero temperature divisor clears the temperature result
	a_fault_zero_temp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && fault_s2 |-> temp_s2 == 16'd0)
		else $error("temperature not cleared on divide fault");

	// a stall holds the finished result
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid && $stable(temperature_decidegrees))
		else $error("stalled result lost");

endmodule
